// ===== rtl/tpl_pkg.sv =====
// Package for the tree pruning likelihood core: codes, widths, types and defaults.
// Used by tpl_mac, tpl_ctrl and tree_pruning_likelihood_core. No dependencies.
package tpl_pkg;

    localparam int VAL_W   = 32;
    localparam int NODE_W  = 9;
    localparam int EIDX_W  = 9;
    localparam int STATE_W = 6;
    localparam int OPOS_W  = 8;
    localparam int CMD_W   = 3;

    localparam int NS_W    = 7;
    localparam int ROOT_W  = 8;
    localparam int ECNT_W  = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam int DEF_MAX_NODES  = 256;
    localparam int DEF_MAX_EDGES  = 512;
    localparam int DEF_MAX_STATES = 4;

    localparam logic [NS_W-1:0] NUM_STATES_RST = NS_W'(4);

    localparam logic [CMD_W-1:0] CMD_EDGE   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_MATRIX = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LIK    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ORDER  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RUN    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_STATES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_ROW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_COUNT = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ORD_RD,
        ST_ORD_CHK,
        ST_EDGE_RD,
        ST_EDGE_CHK,
        ST_DOT_RD,
        ST_DOT_MUL,
        ST_DOT_ACC,
        ST_NODE_MUL,
        ST_NODE_WR,
        ST_EMIT_RD,
        ST_EMIT_PUT
    } ctrl_state_t;

    typedef enum logic [1:0] {
        MAC_IDLE,
        MAC_MUL,
        MAC_FIRST,
        MAC_ACC
    } mac_op_t;

    typedef struct packed {
        mac_op_t          op;
        logic [VAL_W-1:0] a;
        logic [VAL_W-1:0] b;
    } mac_cmd_t;

    typedef struct packed {
        logic [VAL_W-1:0] prod;
        logic [VAL_W-1:0] acc;
    } mac_res_t;

    typedef struct packed {
        logic [NS_W-1:0]   num_states;
        logic [ROOT_W-1:0] root_row;
        logic [ECNT_W-1:0] edge_count;
    } cfg_t;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [EIDX_W-1:0]  edge_index;
        logic [NODE_W-1:0]  parent_node;
        logic [NODE_W-1:0]  child_node;
        logic [NODE_W-1:0]  node;
        logic [STATE_W-1:0] row_state;
        logic [STATE_W-1:0] col_state;
        logic [VAL_W-1:0]   value;
        logic [OPOS_W-1:0]  order_pos;
        logic [NODE_W-1:0]  order_len;
    } in_item_t;

    typedef struct packed {
        logic [STATE_W-1:0] state_index;
        logic [VAL_W-1:0]   likelihood;
        logic               last;
        logic               missing_child;
    } emit_t;

endpackage

// ===== rtl/tpl_mac.sv =====
// Shared multiply and saturating accumulate unit of the pruning core.
// Depends on tpl_pkg.
module tpl_mac
    import tpl_pkg::*;
(
    input  logic     aclk,
    input  mac_cmd_t cmd,
    output mac_res_t res
);

    logic [VAL_W-1:0]   prod_reg;
    logic [VAL_W-1:0]   acc_reg;
    logic [2*VAL_W-1:0] full_prod;
    logic [VAL_W:0]     sum;

    assign full_prod = (2*VAL_W)'(cmd.a) * (2*VAL_W)'(cmd.b);
    assign sum = (cmd.op == MAC_FIRST) ? {1'b0, prod_reg}
                                       : {1'b0, acc_reg} + {1'b0, prod_reg};

    always_ff @(posedge aclk) begin
        case (cmd.op)
            MAC_MUL: begin
                prod_reg <= full_prod[2*VAL_W-1:VAL_W];
            end
            MAC_FIRST, MAC_ACC: begin
                acc_reg <= sum[VAL_W] ? {VAL_W{1'b1}} : sum[VAL_W-1:0];
            end
            default: begin
            end
        endcase
    end

    assign res.prod = prod_reg;
    assign res.acc  = acc_reg;

endmodule

// ===== rtl/tpl_ctrl.sv =====
// Sequencer and stores of the pruning core: tables, order list, likelihood rows.
// Depends on tpl_pkg; drives the shared tpl_mac unit.
module tpl_ctrl
    import tpl_pkg::*;
#(
    parameter int MAX_NODES  = DEF_MAX_NODES,
    parameter int MAX_EDGES  = DEF_MAX_EDGES,
    parameter int MAX_STATES = DEF_MAX_STATES
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  cfg_t     cfg,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t item,
    output mac_cmd_t mac_cmd,
    input  mac_res_t mac_res,
    output logic     emit_valid,
    input  logic     emit_ready,
    output emit_t    emit
);

    localparam int S    = MAX_STATES;
    localparam int NSW  = $clog2(S + 1);
    localparam int EAW  = $clog2(MAX_EDGES);
    localparam int ECW  = $clog2(MAX_EDGES + 1);
    localparam int OAW  = $clog2(MAX_NODES);
    localparam int OCW  = $clog2(MAX_NODES + 1);
    localparam int LAW  = $clog2(MAX_NODES * S);
    localparam int PAW  = $clog2(MAX_EDGES * S * S);

    logic [2*NODE_W-1:0] edge_mem  [MAX_EDGES];
    logic [VAL_W-1:0]    trans_mem [MAX_EDGES*S*S];
    logic [VAL_W-1:0]    lik_mem   [MAX_NODES*S];
    logic [NODE_W-1:0]   order_mem [MAX_NODES];

    logic [2*NODE_W-1:0] edge_q_reg;
    logic [VAL_W-1:0]    trans_q_reg;
    logic [VAL_W-1:0]    lik_q_reg;
    logic [NODE_W-1:0]   order_q_reg;

    ctrl_state_t state_reg, state_next;
    logic [OCW-1:0]    i_reg, i_next, olen_reg, olen_next;
    logic [ECW-1:0]    k_reg, k_next, ne_reg, ne_next;
    logic [NSW-1:0]    ns_reg, ns_next, g_reg, g_next, j_reg, j_next;
    logic              side_reg, side_next;
    logic [1:0]        found_reg, found_next;
    logic [NODE_W-1:0] v_reg, v_next, c1_reg, c1_next, c2_reg, c2_next;
    logic [EAW-1:0]    e1_reg, e1_next, e2_reg, e2_next;
    logic [VAL_W-1:0]  s1_reg, s1_next;
    logic              miss_reg, miss_next;
    logic [ROOT_W-1:0] root_reg, root_next;

    logic              accept;
    logic              order_ok;
    logic              child_ok;
    logic              root_ok;
    logic [NODE_W-1:0] child;
    logic [EAW-1:0]    edge_sel;
    logic [NODE_W-1:0] e_par, e_chi;

    logic              edge_we, trans_we, lik_we, order_we;
    logic [EAW-1:0]    edge_waddr;
    logic [PAW-1:0]    trans_waddr, trans_raddr;
    logic [LAW-1:0]    lik_waddr, lik_raddr;
    logic [VAL_W-1:0]  lik_wdata;
    logic [OAW-1:0]    order_waddr;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign order_ok = (order_q_reg != '0) && (32'(order_q_reg) <= MAX_NODES);
    assign child    = side_reg ? c2_reg : c1_reg;
    assign edge_sel = side_reg ? e2_reg : e1_reg;
    assign child_ok = (child != '0) && (32'(child) <= MAX_NODES);
    assign root_ok  = 32'(root_reg) < MAX_NODES;
    assign e_par    = edge_q_reg[2*NODE_W-1:NODE_W];
    assign e_chi    = edge_q_reg[NODE_W-1:0];

    // store writes (loads and node rows) and read addresses
    always_comb begin
        edge_we     = accept && item.cmd == CMD_EDGE && 32'(item.edge_index) < MAX_EDGES;
        trans_we    = accept && item.cmd == CMD_MATRIX && 32'(item.edge_index) < MAX_EDGES
                      && 32'(item.row_state) < S && 32'(item.col_state) < S;
        order_we    = accept && item.cmd == CMD_ORDER && 32'(item.order_pos) < MAX_NODES;
        edge_waddr  = EAW'(item.edge_index);
        trans_waddr = PAW'((32'(item.edge_index) * S + 32'(item.row_state)) * S
                           + 32'(item.col_state));
        order_waddr = OAW'(item.order_pos);
        if (state_reg == ST_NODE_WR) begin
            lik_we    = 1'b1;
            lik_waddr = LAW'((32'(v_reg) - 1) * S + 32'(g_reg));
            lik_wdata = mac_res.prod;
        end else begin
            lik_we    = accept && item.cmd == CMD_LIK && item.node != '0
                        && 32'(item.node) <= MAX_NODES && 32'(item.row_state) < S;
            lik_waddr = LAW'((32'(item.node) - 1) * S + 32'(item.row_state));
            lik_wdata = item.value;
        end
        trans_raddr = PAW'((32'(edge_sel) * S + 32'(g_reg)) * S + 32'(j_reg));
        if (state_reg == ST_EMIT_RD || state_reg == ST_EMIT_PUT) begin
            lik_raddr = root_ok ? LAW'(32'(root_reg) * S + 32'(g_reg)) : '0;
        end else begin
            lik_raddr = child_ok ? LAW'((32'(child) - 1) * S + 32'(j_reg)) : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (edge_we) begin
            edge_mem[edge_waddr] <= {item.parent_node, item.child_node};
        end
        edge_q_reg <= edge_mem[k_reg[EAW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (trans_we) begin
            trans_mem[trans_waddr] <= item.value;
        end
        trans_q_reg <= trans_mem[trans_raddr];
    end

    always_ff @(posedge aclk) begin
        if (lik_we) begin
            lik_mem[lik_waddr] <= lik_wdata;
        end
        lik_q_reg <= lik_mem[lik_raddr];
    end

    always_ff @(posedge aclk) begin
        if (order_we) begin
            order_mem[order_waddr] <= item.node;
        end
        order_q_reg <= order_mem[i_reg[OAW-1:0]];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && item.cmd == CMD_RUN) state_next = ST_ORD_RD;
            end
            ST_ORD_RD: begin
                state_next = (i_reg == olen_reg) ? ST_EMIT_RD : ST_ORD_CHK;
            end
            ST_ORD_CHK: begin
                state_next = order_ok ? ST_EDGE_RD : ST_ORD_RD;
            end
            ST_EDGE_RD: begin
                if (found_reg == 2'd2) state_next = ST_DOT_RD;
                else if (k_reg == ne_reg) state_next = ST_ORD_RD;
                else state_next = ST_EDGE_CHK;
            end
            ST_EDGE_CHK: begin
                state_next = ST_EDGE_RD;
            end
            ST_DOT_RD: begin
                state_next = ST_DOT_MUL;
            end
            ST_DOT_MUL: begin
                state_next = ST_DOT_ACC;
            end
            ST_DOT_ACC: begin
                if (j_reg == ns_reg - 1'b1 && side_reg) state_next = ST_NODE_MUL;
                else state_next = ST_DOT_RD;
            end
            ST_NODE_MUL: begin
                state_next = ST_NODE_WR;
            end
            ST_NODE_WR: begin
                state_next = (g_reg == ns_reg - 1'b1) ? ST_ORD_RD : ST_DOT_RD;
            end
            ST_EMIT_RD: begin
                state_next = ST_EMIT_PUT;
            end
            ST_EMIT_PUT: begin
                if (emit_ready) state_next = (g_reg == ns_reg - 1'b1) ? ST_IDLE : ST_EMIT_RD;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        i_next     = i_reg;
        olen_next  = olen_reg;
        k_next     = k_reg;
        ne_next    = ne_reg;
        ns_next    = ns_reg;
        g_next     = g_reg;
        j_next     = j_reg;
        side_next  = side_reg;
        found_next = found_reg;
        v_next     = v_reg;
        c1_next    = c1_reg;
        c2_next    = c2_reg;
        e1_next    = e1_reg;
        e2_next    = e2_reg;
        s1_next    = s1_reg;
        miss_next  = miss_reg;
        root_next  = root_reg;
        mac_cmd.op = MAC_IDLE;
        mac_cmd.a  = s1_reg;
        mac_cmd.b  = mac_res.acc;
        emit_valid = 1'b0;
        emit.state_index   = STATE_W'(g_reg);
        emit.likelihood    = root_ok ? lik_q_reg : '0;
        emit.last          = (g_reg == ns_reg - 1'b1);
        emit.missing_child = miss_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && item.cmd == CMD_RUN) begin
                    i_next    = '0;
                    olen_next = (32'(item.order_len) > MAX_NODES) ? OCW'(MAX_NODES)
                                                                : OCW'(item.order_len);
                    ne_next   = (32'(cfg.edge_count) > MAX_EDGES) ? ECW'(MAX_EDGES)
                                                                : ECW'(cfg.edge_count);
                    if (cfg.num_states == '0) ns_next = NSW'(1);
                    else if (32'(cfg.num_states) > S) ns_next = NSW'(S);
                    else ns_next = NSW'(cfg.num_states);
                    root_next = cfg.root_row;
                    miss_next = 1'b0;
                end
            end
            ST_ORD_RD: begin
                g_next = '0;
            end
            ST_ORD_CHK: begin
                v_next     = order_q_reg;
                k_next     = '0;
                found_next = '0;
                if (!order_ok) begin
                    miss_next = 1'b1;
                    i_next    = i_reg + 1'b1;
                end
            end
            ST_EDGE_RD: begin
                side_next = 1'b0;
                j_next    = '0;
                g_next    = '0;
                if (found_reg != 2'd2 && k_reg == ne_reg) begin
                    miss_next = 1'b1;
                    i_next    = i_reg + 1'b1;
                end
            end
            ST_EDGE_CHK: begin
                if (e_par == v_reg) begin
                    if (found_reg == 2'd0) begin
                        e1_next = k_reg[EAW-1:0];
                        c1_next = e_chi;
                    end else begin
                        e2_next = k_reg[EAW-1:0];
                        c2_next = e_chi;
                    end
                    found_next = found_reg + 1'b1;
                end
                k_next = k_reg + 1'b1;
            end
            ST_DOT_RD: begin
                if (side_reg && j_reg == '0) s1_next = mac_res.acc;
            end
            ST_DOT_MUL: begin
                mac_cmd.op = MAC_MUL;
                mac_cmd.a  = child_ok ? lik_q_reg : '0;
                mac_cmd.b  = trans_q_reg;
            end
            ST_DOT_ACC: begin
                mac_cmd.op = (j_reg == '0) ? MAC_FIRST : MAC_ACC;
                if (j_reg == ns_reg - 1'b1) begin
                    j_next    = '0;
                    side_next = !side_reg;
                end else begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_NODE_MUL: begin
                mac_cmd.op = MAC_MUL;
            end
            ST_NODE_WR: begin
                if (g_reg == ns_reg - 1'b1) begin
                    i_next = i_reg + 1'b1;
                end else begin
                    g_next = g_reg + 1'b1;
                end
            end
            ST_EMIT_RD: begin
            end
            ST_EMIT_PUT: begin
                emit_valid = 1'b1;
                if (emit_ready) g_next = g_reg + 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            miss_reg  <= 1'b0;
            found_reg <= '0;
        end else begin
            state_reg <= state_next;
            miss_reg  <= miss_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge aclk) begin
        i_reg    <= i_next;
        olen_reg <= olen_next;
        k_reg    <= k_next;
        ne_reg   <= ne_next;
        ns_reg   <= ns_next;
        g_reg    <= g_next;
        j_reg    <= j_next;
        side_reg <= side_next;
        v_reg    <= v_next;
        c1_reg   <= c1_next;
        c2_reg   <= c2_next;
        e1_reg   <= e1_next;
        e2_reg   <= e2_next;
        s1_reg   <= s1_next;
        root_reg <= root_next;
    end

`ifndef SYNTH
    a_found_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        found_reg != 2'd3)
        else $error("edge search found more than two children");
    a_write_has_edges: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_NODE_WR |-> found_reg == 2'd2)
        else $error("node row written without two child edges");
    a_run_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && item.cmd == CMD_RUN) |=> state_reg == ST_ORD_RD)
        else $error("run transaction did not start the walk");
    a_emit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_valid |-> g_reg < ns_reg)
        else $error("emitted state beyond row length");
`endif

endmodule

// ===== rtl/tree_pruning_likelihood_core.sv =====
// Tree pruning likelihood core, top level: config registers, output register.
// A run walks the order entries, searches the edges of each node and computes each
// visited node's row on the shared multiplier, then emits the root row state by
// state. One transaction at a time.
// aresetn (synchronous, active low) clears control and config; the stores hold
// whatever was loaded and stay undefined until written.
module tree_pruning_likelihood_core
    import tpl_pkg::*;
#(
    parameter int MAX_NODES  = DEF_MAX_NODES,
    parameter int MAX_EDGES  = DEF_MAX_EDGES,
    parameter int MAX_STATES = DEF_MAX_STATES
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [CMD_W-1:0]      s_cmd,
    input  logic [EIDX_W-1:0]     s_edge_index,
    input  logic [NODE_W-1:0]     s_parent_node,
    input  logic [NODE_W-1:0]     s_child_node,
    input  logic [NODE_W-1:0]     s_node,
    input  logic [STATE_W-1:0]    s_row_state,
    input  logic [STATE_W-1:0]    s_col_state,
    input  logic [VAL_W-1:0]      s_value,
    input  logic [OPOS_W-1:0]     s_order_pos,
    input  logic [NODE_W-1:0]     s_order_len,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [STATE_W-1:0]    m_state_index,
    output logic [VAL_W-1:0]      m_likelihood,
    output logic                  m_last,
    output logic                  m_missing_child
);

    cfg_t     cfg_reg;
    in_item_t item;
    mac_cmd_t mac_cmd;
    mac_res_t mac_res;
    emit_t    emit;
    emit_t    out_reg;
    logic     emit_valid, emit_ready;
    logic     m_valid_reg;

    assign item = '{cmd: s_cmd, edge_index: s_edge_index, parent_node: s_parent_node,
                    child_node: s_child_node, node: s_node, row_state: s_row_state,
                    col_state: s_col_state, value: s_value, order_pos: s_order_pos,
                    order_len: s_order_len};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.num_states <= NUM_STATES_RST;
            cfg_reg.root_row   <= '0;
            cfg_reg.edge_count <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_NUM_STATES: cfg_reg.num_states <= cfg_wdata[NS_W-1:0];
                CFG_ROOT_ROW:   cfg_reg.root_row   <= cfg_wdata[ROOT_W-1:0];
                CFG_EDGE_COUNT: cfg_reg.edge_count <= cfg_wdata[ECNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    tpl_ctrl #(
        .MAX_NODES  (MAX_NODES),
        .MAX_EDGES  (MAX_EDGES),
        .MAX_STATES (MAX_STATES)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .item       (item),
        .mac_cmd    (mac_cmd),
        .mac_res    (mac_res),
        .emit_valid (emit_valid),
        .emit_ready (emit_ready),
        .emit       (emit)
    );

    tpl_mac u_mac (
        .aclk (aclk),
        .cmd  (mac_cmd),
        .res  (mac_res)
    );

    // hold a result until taken
    assign emit_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit_ready) begin
            m_valid_reg <= emit_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_ready && emit_valid) begin
            out_reg <= emit;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_state_index   = out_reg.state_index;
    assign m_likelihood    = out_reg.likelihood;
    assign m_last          = out_reg.last;
    assign m_missing_child = out_reg.missing_child;

endmodule
